// ===== rtl/let_pkg.sv =====
// ----------------------------------------------------------------------------
// let_pkg
// Shared constants, types and the gray conversion of the Laplacian edge block.
// ----------------------------------------------------------------------------
package let_pkg;

	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;

	localparam int COLOR_W    = 8;
	localparam int GRAY_W     = 8;
	localparam int DIM_W      = 11;
	localparam int THR_W      = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EDGE_THRESHOLD = 2'd2;

	localparam logic [DIM_W-1:0] RST_FRAME_WIDTH    = 11'd640;
	localparam logic [DIM_W-1:0] RST_FRAME_HEIGHT   = 11'd480;
	localparam logic [THR_W-1:0] RST_EDGE_THRESHOLD = 8'd0;

	localparam int OUTQ_DEPTH = 3;
	localparam int LVL_W      = $clog2(OUTQ_DEPTH + 1);
	localparam int PTR_W      = $clog2(OUTQ_DEPTH);

	typedef struct packed {
		logic [GRAY_W-1:0] gray;
		logic              has_out;
		logic              eof;
		logic              left_edge;
		logic              right_edge;
		logic              top_edge;
		logic              bottom_edge;
		logic              one_col;
	} let_ctl_t;

	typedef struct packed {
		logic edge_white;
		logic end_of_frame;
	} let_res_t;

	function automatic logic [GRAY_W-1:0] gray_of(
		input logic [COLOR_W-1:0] r,
		input logic [COLOR_W-1:0] g,
		input logic [COLOR_W-1:0] b
	);
		logic [17:0] acc;
		acc = 18'(r) * 18'd77 + 18'(g) * 18'd150 + 18'(b) * 18'd29;
		return acc[15:8];
	endfunction

endpackage

// ===== rtl/let_if.sv =====
// ----------------------------------------------------------------------------
// let_if
// Valid/ready channels for incoming pixel items and outgoing result items.
// ----------------------------------------------------------------------------
interface let_pixel_if;
	logic                        valid;
	logic                        ready;
	logic                        action;
	logic [let_pkg::COLOR_W-1:0] red;
	logic [let_pkg::COLOR_W-1:0] green;
	logic [let_pkg::COLOR_W-1:0] blue;

	modport source (output valid, action, red, green, blue, input ready);
	modport sink (input valid, action, red, green, blue, output ready);
endinterface

interface let_result_if;
	logic valid;
	logic ready;
	logic edge_white;
	logic end_of_frame;

	modport source (output valid, edge_white, end_of_frame, input ready);
	modport sink (input valid, edge_white, end_of_frame, output ready);
endinterface

// ===== rtl/let_line_mem.sv =====
// ----------------------------------------------------------------------------
// let_line_mem
// Line store of two gray rows per column, one read and one write port.
// A read of the entry written in the same cycle returns the new data.
// ----------------------------------------------------------------------------
module let_line_mem #(
	parameter int DEPTH  = let_pkg::DEF_MAX_WIDTH,
	parameter int DATA_W = 2 * let_pkg::GRAY_W
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [DATA_W-1:0]        rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [DATA_W-1:0]        wr_data
);
	localparam int ADDR_W = $clog2(DEPTH);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rd_q;
	logic [DATA_W-1:0] byp_data_q;
	logic              byp_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q       <= mem[rd_addr];
			byp_data_q <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else if (rd_en) begin
			byp_q <= wr_en && (wr_addr == ADDR_W'(rd_addr));
		end
	end

	assign rd_data = byp_q ? byp_data_q : rd_q;
endmodule

// ===== rtl/let_front.sv =====
// ----------------------------------------------------------------------------
// let_front
// Configuration registers, frame position counters and gray conversion.
// Decides per item whether it is taken, starts the line store read.
// ----------------------------------------------------------------------------
module let_front #(
	parameter int MAX_WIDTH  = let_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = let_pkg::DEF_MAX_HEIGHT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [let_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [let_pkg::CFG_DATA_W-1:0] wr_data,
	input  logic                           accept,
	input  logic                           action,
	input  logic [let_pkg::COLOR_W-1:0]    red,
	input  logic [let_pkg::COLOR_W-1:0]    green,
	input  logic [let_pkg::COLOR_W-1:0]    blue,
	output logic                           go,
	output logic [$clog2(MAX_WIDTH)-1:0]   rd_addr,
	output let_pkg::let_ctl_t              ctl,
	output logic [let_pkg::THR_W-1:0]      thr
);
	import let_pkg::*;

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int WID_W = $clog2(MAX_WIDTH + 1);
	localparam int HGT_W = $clog2(MAX_HEIGHT + 1);
	localparam int ROW_W = $clog2(MAX_HEIGHT + 2);
	localparam int CMP_W = ROW_W + 1;

	function automatic logic [WID_W-1:0] clamp_w(input logic [DIM_W-1:0] v);
		if (v == '0) return WID_W'(1);
		if (32'(v) > MAX_WIDTH) return WID_W'(MAX_WIDTH);
		return WID_W'(v);
	endfunction

	function automatic logic [HGT_W-1:0] clamp_h(input logic [DIM_W-1:0] v);
		if (v == '0) return HGT_W'(1);
		if (32'(v) > MAX_HEIGHT) return HGT_W'(MAX_HEIGHT);
		return HGT_W'(v);
	endfunction

	logic [WID_W-1:0] width_q;
	logic [HGT_W-1:0] height_q;
	logic [THR_W-1:0] thr_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;

	logic [COL_W-1:0] cx;
	logic [ROW_W-1:0] ry;
	logic [CMP_W-1:0] ry_x;
	logic [CMP_W-1:0] h_x;
	logic [WID_W:0]   col_nx;
	logic             restart;
	logic             in_frame;
	logic             ignore;
	logic             last_col;

	always_comb begin
		h_x      = CMP_W'(height_q);
		restart  = (WID_W'(col_q) >= width_q) || (CMP_W'(row_q) > h_x + CMP_W'(1));
		cx       = restart ? '0 : col_q;
		ry       = restart ? '0 : row_q;
		ry_x     = CMP_W'(ry);
		in_frame = ry_x < h_x;
		ignore   = action && in_frame;
		col_nx   = (WID_W + 1)'(cx) + (WID_W + 1)'(1);
		last_col = col_nx == (WID_W + 1)'(width_q);

		ctl.gray        = in_frame ? gray_of(red, green, blue) : '0;
		ctl.has_out     = (ry_x >= CMP_W'(2)) || ((ry_x == CMP_W'(1)) && (cx != '0));
		ctl.eof         = (ry_x == h_x + CMP_W'(1)) && (cx == '0);
		ctl.left_edge   = (cx == '0) ? (width_q == WID_W'(1)) : (cx == COL_W'(1));
		ctl.right_edge  = cx == '0;
		ctl.top_edge    = (cx != '0) ? (ry_x == CMP_W'(1)) : (ry_x == CMP_W'(2));
		ctl.bottom_edge = (cx != '0) ? (ry_x >= h_x) : (ry_x >= h_x + CMP_W'(1));
		ctl.one_col     = width_q == WID_W'(1);
	end

	assign go      = accept && !ignore;
	assign rd_addr = cx;
	assign thr     = thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= clamp_w(RST_FRAME_WIDTH);
			height_q <= clamp_h(RST_FRAME_HEIGHT);
			thr_q    <= RST_EDGE_THRESHOLD;
			col_q    <= '0;
			row_q    <= '0;
		end else begin
			if (wr_en) begin
				unique case (wr_index)
					REG_FRAME_WIDTH:    width_q  <= clamp_w(wr_data);
					REG_FRAME_HEIGHT:   height_q <= clamp_h(wr_data);
					REG_EDGE_THRESHOLD: thr_q    <= wr_data[THR_W-1:0];
					default: ;
				endcase
			end
			if (accept) begin
				if (ignore) begin
					col_q <= cx;
					row_q <= ry;
				end else if (ctl.eof) begin
					col_q <= '0;
					row_q <= '0;
				end else if (last_col) begin
					col_q <= '0;
					row_q <= ry + ROW_W'(1);
				end else begin
					col_q <= col_nx[COL_W-1:0];
					row_q <= ry;
				end
			end
		end
	end
endmodule

// ===== rtl/let_kernel.sv =====
// ----------------------------------------------------------------------------
// let_kernel
// Second stage: takes the line store data, writes the shifted column back,
// keeps the last two columns and forms the thresholded Laplacian.
// ----------------------------------------------------------------------------
module let_kernel #(
	parameter int MAX_WIDTH = let_pkg::DEF_MAX_WIDTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            go,
	input  logic [$clog2(MAX_WIDTH)-1:0]    addr,
	input  let_pkg::let_ctl_t               ctl,
	input  logic [let_pkg::THR_W-1:0]       thr,
	input  logic [2*let_pkg::GRAY_W-1:0]    rd_data,
	output logic                            wr_en,
	output logic [$clog2(MAX_WIDTH)-1:0]    wr_addr,
	output logic [2*let_pkg::GRAY_W-1:0]    wr_data,
	output logic                            push,
	output let_pkg::let_res_t               res
);
	import let_pkg::*;

	localparam int COL_W = $clog2(MAX_WIDTH);

	logic              v_s1;
	let_ctl_t          ctl_s1;
	logic [COL_W-1:0]  addr_s1;
	logic [GRAY_W-1:0] t1_q;
	logic [GRAY_W-1:0] m1_q;
	logic [GRAY_W-1:0] b1_q;
	logic [GRAY_W-1:0] m2_q;

	logic [GRAY_W-1:0]  top_px;
	logic [GRAY_W-1:0]  mid_px;
	logic [GRAY_W-1:0]  c;
	logic [GRAY_W-1:0]  l;
	logic [GRAY_W-1:0]  r;
	logic [GRAY_W-1:0]  u;
	logic [GRAY_W-1:0]  d;
	logic [GRAY_W+1:0]  neg;
	logic signed [10:0] sum;
	logic               white;

	always_comb begin
		top_px = rd_data[2*GRAY_W-1:GRAY_W];
		mid_px = rd_data[GRAY_W-1:0];
		if (ctl_s1.one_col) begin
			c = top_px;
			l = c;
			r = c;
			u = ctl_s1.top_edge ? c : t1_q;
			d = ctl_s1.bottom_edge ? c : mid_px;
		end else begin
			c = m1_q;
			l = ctl_s1.left_edge ? c : m2_q;
			r = ctl_s1.right_edge ? c : mid_px;
			u = ctl_s1.top_edge ? c : t1_q;
			d = ctl_s1.bottom_edge ? c : b1_q;
		end
		neg = (GRAY_W + 2)'(l) + (GRAY_W + 2)'(r) + (GRAY_W + 2)'(u) + (GRAY_W + 2)'(d);
		sum = $signed({1'b0, c, 2'b00}) - $signed({1'b0, neg});
		if (sum > 11'sd255) begin
			white = thr != {THR_W{1'b1}};
		end else begin
			white = sum > $signed({3'b000, thr});
		end
	end

	assign wr_en            = v_s1;
	assign wr_addr          = addr_s1;
	assign wr_data          = {mid_px, ctl_s1.gray};
	assign push             = v_s1 && ctl_s1.has_out;
	assign res.edge_white   = white;
	assign res.end_of_frame = ctl_s1.eof;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= go;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			ctl_s1  <= ctl;
			addr_s1 <= addr;
		end
		if (v_s1) begin
			t1_q <= top_px;
			m1_q <= mid_px;
			b1_q <= ctl_s1.gray;
			m2_q <= m1_q;
		end
	end
endmodule

// ===== rtl/let_out_queue.sv =====
// ----------------------------------------------------------------------------
// let_out_queue
// Three-entry result queue that drives the result channel.
// ----------------------------------------------------------------------------
module let_out_queue (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  let_pkg::let_res_t          push_data,
	output logic [let_pkg::LVL_W-1:0]  level,
	let_result_if.source               result
);
	import let_pkg::*;

	let_res_t          slot_q [OUTQ_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [LVL_W-1:0]  level_q;
	logic              pop;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(OUTQ_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign pop                 = result.valid && result.ready;
	assign result.valid        = level_q != '0;
	assign result.edge_white   = slot_q[rd_ptr_q].edge_white;
	assign result.end_of_frame = slot_q[rd_ptr_q].end_of_frame;
	assign level               = level_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				level_q <= level_q + LVL_W'(1);
			end else if (pop && !push) begin
				level_q <= level_q - LVL_W'(1);
			end
		end
	end
endmodule

// ===== rtl/laplacian_edge_threshold.sv =====
// A result is offered once the kernel stage and then the result queue have registered it.
// One item per cycle (one line store read and write each) while the queue has room.
// Results lag their pixels by one row plus one pixel; drain items flush the last row.
// Reset clears the position counters, registers and result queue; the line store is
// not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// laplacian_edge_threshold
// Gray conversion, 3x3 four-neighbor Laplacian over a two-row line store and
// threshold to a black or white result item per pixel.
// ----------------------------------------------------------------------------
module laplacian_edge_threshold #(
	parameter int MAX_WIDTH  = let_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = let_pkg::DEF_MAX_HEIGHT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [let_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [let_pkg::CFG_DATA_W-1:0] wr_data,
	let_pixel_if.sink                      pixel,
	let_result_if.source                   result
);
	import let_pkg::*;

	localparam int COL_W = $clog2(MAX_WIDTH);

	logic                  accept;
	logic                  go;
	logic                  room;
	logic                  push;
	logic [LVL_W-1:0]      level;
	logic [COL_W-1:0]      rd_addr;
	logic [COL_W-1:0]      mem_wr_addr;
	logic                  mem_wr_en;
	logic [2*GRAY_W-1:0]   mem_rd_data;
	logic [2*GRAY_W-1:0]   mem_wr_data;
	logic [THR_W-1:0]      thr;
	let_ctl_t              ctl;
	let_res_t              res;

	assign room        = (level < LVL_W'(OUTQ_DEPTH - 1)) ||
	                     ((level == LVL_W'(OUTQ_DEPTH - 1)) && !push);
	assign pixel.ready = room;
	assign accept      = pixel.valid && pixel.ready;

	let_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.accept   (accept),
		.action   (pixel.action),
		.red      (pixel.red),
		.green    (pixel.green),
		.blue     (pixel.blue),
		.go       (go),
		.rd_addr  (rd_addr),
		.ctl      (ctl),
		.thr      (thr)
	);

	let_line_mem #(
		.DEPTH  (MAX_WIDTH),
		.DATA_W (2 * GRAY_W)
	) u_line_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (go),
		.rd_addr (rd_addr),
		.rd_data (mem_rd_data),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data)
	);

	let_kernel #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_kernel (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (go),
		.addr    (rd_addr),
		.ctl     (ctl),
		.thr     (thr),
		.rd_data (mem_rd_data),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.push    (push),
		.res     (res)
	);

	let_out_queue u_out_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (res),
		.level     (level),
		.result    (result)
	);

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (level != LVL_W'(OUTQ_DEPTH)))
		else $error("Result queue overflow.");

	assert property (@(posedge clk) disable iff (!arst_n)
		mem_wr_en |-> $past(go))
		else $error("Line store written without a taken item.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !(result.valid && result.ready)) |=> (level == $past(level) + LVL_W'(1)))
		else $error("Result queue level lost a pushed item.");
`endif
endmodule
